@@ design/sgm_pkg.sv @@
package sgm_pkg;

	// Default capacity of the line stores, in pixels per row.
	localparam int MAX_WIDTH_DEF = 1024;

	// Field widths.
	localparam int PIX_W   = 8;
	localparam int RGB_W   = 24;
	localparam int ROW_W   = 16;
	localparam int CFG_W   = 16;
	localparam int IMG_W_W = 11;

	// Configuration register indexes.
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
	localparam logic [ROW_W-1:0]   IMAGE_HEIGHT_RST = 16'd480;

	localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

	typedef logic [RGB_W-1:0] rgb_t;

	// Eight taps of the 3x3 window; the center tap does not enter Sobel.
	typedef struct packed {
		rgb_t lt;
		rgb_t lm;
		rgb_t lb;
		rgb_t ct;
		rgb_t cb;
		rgb_t rt;
		rgb_t rm;
		rgb_t rb;
	} win_t;

	typedef struct packed {
		logic [PIX_W-1:0] lt;
		logic [PIX_W-1:0] lm;
		logic [PIX_W-1:0] lb;
		logic [PIX_W-1:0] ct;
		logic [PIX_W-1:0] cb;
		logic [PIX_W-1:0] rt;
		logic [PIX_W-1:0] rm;
		logic [PIX_W-1:0] rb;
	} lane_win_t;

	// Tag that travels with a request down the pipeline.
	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

	// Partial state of the restoring square root.
	typedef struct packed {
		logic [8:0] rem;
		logic [7:0] root;
	} sq_t;

	// One result bit of the restoring square root, two radicand bits in.
	function automatic sq_t isqrt_step(sq_t cur, logic [1:0] pair);
		logic [10:0] r2;
		logic [10:0] trial;
		sq_t nxt;
		r2 = {cur.rem, pair};
		trial = {1'b0, cur.root, 2'b01};
		if (r2 >= trial) begin
			nxt.rem = 9'(r2 - trial);
			nxt.root = {cur.root[6:0], 1'b1};
		end else begin
			nxt.rem = r2[8:0];
			nxt.root = {cur.root[6:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

@@ design/sgm_line_buf.sv @@
module sgm_line_buf #(
	parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF,
	parameter int AW = $clog2(MAX_WIDTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  sgm_pkg::rgb_t   px,
	output sgm_pkg::win_t   win
);
	import sgm_pkg::*;

	rgb_t upper_mem [MAX_WIDTH];
	rgb_t middle_mem [MAX_WIDTH];
	rgb_t rd_up_s1;
	rgb_t rd_mid_s1;
	logic [5:0][RGB_W-1:0] win_q;

	// The write of a pixel lands after its read, once the pipeline advances, always at a different
	// column than the read of the following pixel.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_up_s1 <= upper_mem[rd_addr];
			rd_mid_s1 <= middle_mem[rd_addr];
		end
		if (wr_en) begin
			upper_mem[wr_addr] <= rd_mid_s1;
			middle_mem[wr_addr] <= px;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (wr_en) begin
			win_q[2:0] <= win_q[5:3];
			win_q[5:3] <= {px, rd_mid_s1, rd_up_s1};
		end
	end

	assign win.lt = win_q[0];
	assign win.lm = win_q[1];
	assign win.lb = win_q[2];
	assign win.ct = win_q[3];
	assign win.cb = win_q[5];
	assign win.rt = rd_up_s1;
	assign win.rm = rd_mid_s1;
	assign win.rb = px;

endmodule

@@ design/sgm_lane.sv @@
module sgm_lane (
	input  logic                clk,
	input  logic                enable,
	input  sgm_pkg::lane_win_t  win,
	output logic [7:0]          mag,
	output logic                over
);
	import sgm_pkg::*;

	logic [9:0] sum_l;
	logic [9:0] sum_r;
	logic [9:0] sum_t;
	logic [9:0] sum_b;
	logic signed [10:0] gx_s2;
	logic signed [10:0] gy_s2;
	logic signed [21:0] px2;
	logic signed [21:0] py2;
	logic [19:0] sqx_s3;
	logic [19:0] sqy_s3;
	logic [20:0] sum;
	sq_t hi_st;
	sq_t lo_st;
	sq_t st_s4;
	logic [7:0] low_s4;
	logic over_s4;

	always_comb begin
		sum_l = 10'(win.lt) + {1'b0, win.lm, 1'b0} + 10'(win.lb);
		sum_r = 10'(win.rt) + {1'b0, win.rm, 1'b0} + 10'(win.rb);
		sum_t = 10'(win.lt) + {1'b0, win.ct, 1'b0} + 10'(win.rt);
		sum_b = 10'(win.lb) + {1'b0, win.cb, 1'b0} + 10'(win.rb);
	end

	assign px2 = gx_s2 * gx_s2;
	assign py2 = gy_s2 * gy_s2;
	assign sum = 21'(sqx_s3) + 21'(sqy_s3);

	// Only radicands below 2^16 need a true root; larger ones saturate.
	always_comb begin
		hi_st = '0;
		for (int i = 0; i < 4; i++) begin
			hi_st = isqrt_step(hi_st, sum[15 - 2 * i -: 2]);
		end
	end

	always_comb begin
		lo_st = st_s4;
		for (int i = 0; i < 4; i++) begin
			lo_st = isqrt_step(lo_st, low_s4[7 - 2 * i -: 2]);
		end
	end

	always_ff @(posedge clk) begin
		if (enable) begin
			gx_s2 <= $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
			gy_s2 <= $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
			sqx_s3 <= px2[19:0];
			sqy_s3 <= py2[19:0];
			st_s4 <= hi_st;
			low_s4 <= sum[7:0];
			over_s4 <= |sum[20:16];
		end
	end

	assign mag = lo_st.root;
	assign over = over_s4;

endmodule

@@ design/sgm_merge.sv @@
module sgm_merge (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              enable,
	input  sgm_pkg::tag_t     tag,
	input  logic [2:0][7:0]   lane_mag,
	input  logic [2:0]        lane_over,
	output logic              out_valid,
	output logic [7:0]        mag_blue,
	output logic [7:0]        mag_green,
	output logic [7:0]        mag_red,
	output logic              saturated,
	output logic              last_of_frame
);
	import sgm_pkg::*;

	logic sat;

	assign sat = |lane_over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (enable) begin
			out_valid <= tag.valid;
		end
	end

	// Any lane over range forces all three channels to full scale.
	always_ff @(posedge clk) begin
		if (enable) begin
			mag_blue <= sat ? MAG_MAX : lane_mag[0];
			mag_green <= sat ? MAG_MAX : lane_mag[1];
			mag_red <= sat ? MAG_MAX : lane_mag[2];
			saturated <= sat;
			last_of_frame <= tag.last;
		end
	end

endmodule

@@ design/sobel_gradient_magnitude_rgb_core.sv @@
// Pipeline: an accepted pixel passes the input and line store read registers, the
// gradient, square and upper-root registers of each lane, and the output register.
// Throughput: one pixel per cycle; the line store read, three channel lanes and
// the output register form one pipeline that moves whenever the output register is free.
// Reset: counters, window and valid flags clear, registers return to 640 x 480;
// line store contents are undefined until written, and no clearing pass is run.
module sobel_gradient_magnitude_rgb_core #(
	parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic                      cfg_index,
	input  logic [sgm_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                pixel_blue,
	input  logic [7:0]                pixel_green,
	input  logic [7:0]                pixel_red,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                mag_blue,
	output logic [7:0]                mag_green,
	output logic [7:0]                mag_red,
	output logic                      saturated,
	output logic                      last_of_frame
);
	import sgm_pkg::*;

	// Column counter indexes the line stores; the effective width can need one more bit.
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int XW = (WW > IMG_W_W) ? WW : IMG_W_W;

	logic [IMG_W_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;
	logic [AW-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic advance;
	logic accept;
	logic [XW-1:0] wx;
	logic [WW-1:0] w_eff;
	logic [WW-1:0] w_m1;
	logic [WW-1:0] c_ext;
	logic [WW-1:0] c_eff;
	logic [ROW_W-1:0] h_eff;
	logic row_end;
	logic frame_end;
	logic produce;

	logic item_s1;
	rgb_t px_s1;
	logic [AW-1:0] addr_s1;
	tag_t tag_s1;
	tag_t tag_s2;
	tag_t tag_s3;
	tag_t tag_s4;

	win_t win;
	lane_win_t lane_win [3];
	logic [2:0][7:0] lane_mag;
	logic [2:0] lane_over;

	// The whole pipeline moves as one; it stops only while a shown result waits.
	assign advance = !out_valid || !out_stall;
	assign in_stall = !advance;
	assign accept = in_valid && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= IMAGE_WIDTH_RST;
			height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= cfg_data[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// Position of the incoming pixel. Width clamps to the line store capacity and
	// both dimensions to at least three; a column beyond the width acts as the last.
	always_comb begin
		wx = XW'(width_q);
		if (wx < XW'(3)) begin
			wx = XW'(3);
		end else if (wx > XW'(MAX_WIDTH)) begin
			wx = XW'(MAX_WIDTH);
		end
		w_eff = WW'(wx);
		w_m1 = w_eff - WW'(1);
		c_ext = WW'(col_q);
		c_eff = (c_ext >= w_eff) ? w_m1 : c_ext;
		h_eff = (height_q < ROW_W'(3)) ? ROW_W'(3) : height_q;
		row_end = (c_eff >= w_m1);
		frame_end = row_end && (row_q >= h_eff - ROW_W'(1));
		produce = (row_q >= ROW_W'(2)) && (c_eff >= WW'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= AW'(c_eff + WW'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= 1'b0;
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (advance) begin
			item_s1 <= in_valid;
			tag_s1.valid <= in_valid && produce;
			tag_s1.last <= frame_end;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1 <= {pixel_red, pixel_green, pixel_blue};
			addr_s1 <= AW'(c_eff);
		end
	end

	sgm_line_buf #(
		.MAX_WIDTH(MAX_WIDTH),
		.AW(AW)
	) u_line_buf (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept),
		.rd_addr(AW'(c_eff)),
		.wr_en(item_s1 && advance),
		.wr_addr(addr_s1),
		.px(px_s1),
		.win(win)
	);

	// Channel k of every tap feeds lane k: blue, green, red.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lane_win[k].lt = win.lt[8 * k +: 8];
			lane_win[k].lm = win.lm[8 * k +: 8];
			lane_win[k].lb = win.lb[8 * k +: 8];
			lane_win[k].ct = win.ct[8 * k +: 8];
			lane_win[k].cb = win.cb[8 * k +: 8];
			lane_win[k].rt = win.rt[8 * k +: 8];
			lane_win[k].rm = win.rm[8 * k +: 8];
			lane_win[k].rb = win.rb[8 * k +: 8];
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_lane
		sgm_lane u_lane (
			.clk(clk),
			.enable(advance),
			.win(lane_win[k]),
			.mag(lane_mag[k]),
			.over(lane_over[k])
		);
	end

	sgm_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.enable(advance),
		.tag(tag_s4),
		.lane_mag(lane_mag),
		.lane_over(lane_over),
		.out_valid(out_valid),
		.mag_blue(mag_blue),
		.mag_green(mag_green),
		.mag_red(mag_red),
		.saturated(saturated),
		.last_of_frame(last_of_frame)
	);

endmodule

@@ design/sgm_checker.sv @@
module sgm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] mag_blue,
	input logic [7:0] mag_green,
	input logic [7:0] mag_red,
	input logic       saturated,
	input logic       last_of_frame
);
	import sgm_pkg::*;

	// A waiting result stops the input side at once.
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while a result waits");

	// With the output register empty the pipeline never holds off a request.
	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output register");

	// Saturation forces every channel to full scale.
	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
		(mag_blue == MAG_MAX) && (mag_green == MAG_MAX) && (mag_red == MAG_MAX))
		else $error("saturated result without full-scale channels");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mag_blue) && $stable(mag_green)
		&& $stable(mag_red) && $stable(saturated) && $stable(last_of_frame))
		else $error("stalled result changed");

endmodule

bind sobel_gradient_magnitude_rgb_core sgm_checker u_sgm_checker (.*);
